### hw/rtl/great_circle_distance_top_defines.svh
// assertion helpers for the great-circle distance block
`ifndef GREAT_CIRCLE_DISTANCE_TOP_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/gcd_pkg.sv
package gcd_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned CORDIC_STAGES  = 30;
  localparam int unsigned SQRT_STAGES    = 31;
  localparam int unsigned PROD_STAGES    = 4;
  // input stage + sine + product stages + sqrt + arcsine + output stage
  localparam int unsigned LATENCY = 1 + CORDIC_STAGES + PROD_STAGES + SQRT_STAGES
                                    + CORDIC_STAGES + 1;

  localparam int unsigned CW = 34;  // cordic datapath width, signed
  localparam int unsigned RW = 62;  // sqrt radicand width

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
    32'd10, 32'd5, 32'd3, 32'd1
  };

endpackage

### hw/rtl/gcd_sin_cordic.sv
module gcd_sin_cordic (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] full_i,
  output logic [30:0] sin_o
);

  localparam int unsigned N = gcd_pkg::CORDIC_STAGES;
  localparam int unsigned W = gcd_pkg::CW;

  logic signed [W-1:0] x_q [N];
  logic signed [W-1:0] y_q [N];
  logic signed [W-1:0] z_q [N];
  logic [31:0] half_w;
  logic [31:0] fold_w;

  // half angle folded into the first quadrant
  assign half_w = {1'b0, full_i[31:1]};
  assign fold_w = (half_w > gcd_pkg::TURN_QUARTER) ? (gcd_pkg::TURN_HALF - half_w) : half_w;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] x_in, y_in, z_in, x_d, y_d, z_d, at;
    if (i == 0) begin : g_first
      assign x_in = gcd_pkg::CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = $signed({2'b00, fold_w});
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end
    assign at = $signed({2'b00, gcd_pkg::ATAN_TURNS[i]});
    always_comb begin
      if (z_in >= 0) begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - at;
      end else begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + at;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  always_comb begin
    if (y_q[N-1] < 0) begin
      sin_o = '0;
    end else if (y_q[N-1] > $signed({3'b000, gcd_pkg::Q30_ONE})) begin
      sin_o = gcd_pkg::Q30_ONE;
    end else begin
      sin_o = y_q[N-1][30:0];
    end
  end

endmodule

### hw/rtl/gcd_isqrt.sv
module gcd_isqrt (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [gcd_pkg::RW-1:0]  rad_i,
  output logic [30:0]             root_o
);

  localparam int unsigned N  = gcd_pkg::SQRT_STAGES;
  localparam int unsigned RW = gcd_pkg::RW;

  logic [33:0]   rem_q  [N];
  logic [30:0]   root_q [N];
  logic [RW-1:0] rad_q  [N];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [33:0]   rem_in, rem_n, trial, rem_d;
    logic [30:0]   root_in, root_d;
    logic [RW-1:0] rad_in;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end
    assign rem_n  = {rem_in[31:0], rad_in[RW-1:RW-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_n >= trial;
    assign rem_d  = ge ? (rem_n - trial) : rem_n;
    assign root_d = {root_in[29:0], ge};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
        rad_q[i]  <= {rad_in[RW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

### hw/rtl/gcd_asin_cordic.sv
module gcd_asin_cordic (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] sin_i,
  input  logic [30:0] cos_i,
  output logic [31:0] angle2_o
);

  localparam int unsigned N = gcd_pkg::CORDIC_STAGES;
  localparam int unsigned W = gcd_pkg::CW;

  logic signed [W-1:0] x_q [N];
  logic signed [W-1:0] y_q [N];
  logic signed [W-1:0] z_q [N];
  logic [30:0] z_clamp;

  // vectoring: drive y to zero, accumulate the angle
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0] x_in, y_in, z_in, x_d, y_d, z_d, at;
    if (i == 0) begin : g_first
      assign x_in = $signed({3'b000, cos_i});
      assign y_in = $signed({3'b000, sin_i});
      assign z_in = '0;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end
    assign at = $signed({2'b00, gcd_pkg::ATAN_TURNS[i]});
    always_comb begin
      if (y_in >= 0) begin
        x_d = x_in + (y_in >>> i);
        y_d = y_in - (x_in >>> i);
        z_d = z_in + at;
      end else begin
        x_d = x_in - (y_in >>> i);
        y_d = y_in + (x_in >>> i);
        z_d = z_in - at;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_d;
        y_q[i] <= y_d;
        z_q[i] <= z_d;
      end
    end
  end

  always_comb begin
    if (z_q[N-1] < 0) begin
      z_clamp = '0;
    end else if (z_q[N-1] > $signed({2'b00, gcd_pkg::TURN_QUARTER})) begin
      z_clamp = gcd_pkg::Q30_ONE;
    end else begin
      z_clamp = z_q[N-1][30:0];
    end
  end

  assign angle2_o = {z_clamp, 1'b0};

endmodule

### hw/rtl/gcd_haversine.sv
module gcd_haversine (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] dt_i,
  input  logic [31:0] dp_i,
  input  logic [31:0] sum_i,
  output logic [31:0] dist_o
);

  logic [30:0] st_w, sp_w, ss_w;
  logic [61:0] st_sq_w, sp_sq_w, ss_sq_w;
  logic [30:0] st2_q, sp2_q, ss2_q;
  logic [30:0] st2_b_q, sp2_b_q;
  logic signed [31:0] diff_q;
  logic [30:0] st2_c_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] tot_w;
  logic [30:0] v_w;
  logic [gcd_pkg::RW-1:0] radu_q, radc_q;
  logic [30:0] u_w, c_w;

  gcd_sin_cordic u_sin_t (.clk_i, .en_i, .full_i(dt_i),  .sin_o(st_w));
  gcd_sin_cordic u_sin_p (.clk_i, .en_i, .full_i(dp_i),  .sin_o(sp_w));
  gcd_sin_cordic u_sin_s (.clk_i, .en_i, .full_i(sum_i), .sin_o(ss_w));

  assign st_sq_w = 62'(st_w) * 62'(st_w);
  assign sp_sq_w = 62'(sp_w) * 62'(sp_w);
  assign ss_sq_w = 62'(ss_w) * 62'(ss_w);

  // v = st2 + sp2*(ss2 - st2), saturated to [0, 1]
  assign tot_w = $signed({33'd0, st2_c_q}) + (prod_q >>> 30);
  always_comb begin
    if (tot_w < 0) begin
      v_w = '0;
    end else if (tot_w > $signed({33'd0, gcd_pkg::Q30_ONE})) begin
      v_w = gcd_pkg::Q30_ONE;
    end else begin
      v_w = tot_w[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st2_q   <= st_sq_w[60:30];
      sp2_q   <= sp_sq_w[60:30];
      ss2_q   <= ss_sq_w[60:30];
      diff_q  <= $signed({1'b0, ss2_q}) - $signed({1'b0, st2_q});
      st2_b_q <= st2_q;
      sp2_b_q <= sp2_q;
      prod_q  <= 64'($signed({1'b0, sp2_b_q})) * 64'(diff_q);
      st2_c_q <= st2_b_q;
      radu_q  <= {1'b0, v_w, 30'd0};
      radc_q  <= {1'b0, gcd_pkg::Q30_ONE - v_w, 30'd0};
    end
  end

  gcd_isqrt u_sqrt_u (.clk_i, .en_i, .rad_i(radu_q), .root_o(u_w));
  gcd_isqrt u_sqrt_c (.clk_i, .en_i, .rad_i(radc_q), .root_o(c_w));

  gcd_asin_cordic u_asin (.clk_i, .en_i, .sin_i(u_w), .cos_i(c_w), .angle2_o(dist_o));

endmodule

### hw/rtl/great_circle_distance_top.sv
// pipeline depth: 97 register stages from an accepted request to its result
// throughput: one request per cycle when not stalled, set by the fully pipelined
// 30-stage sine and arcsine cordics and the 31-stage square root, one iteration per
// register stage; a stall at the output freezes the whole pipeline, nothing is dropped
// reset clears only the stage valid bits, no clearing pass
module great_circle_distance_top #(
  parameter int unsigned ANGLE_BITS = gcd_pkg::ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] theta_a_i,
  input  logic [15:0] phi_a_i,
  input  logic [15:0] theta_b_i,
  input  logic [15:0] phi_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] arc_length_o
);

  `include "great_circle_distance_top_defines.svh"

  localparam int unsigned WS  = 32 - ANGLE_BITS;
  localparam int unsigned LAT = gcd_pkg::LATENCY;
  localparam logic [32:0] RND = (33'd1 << WS) >> 1;

  logic           en;
  logic [LAT-1:0] vld_q;
  logic [31:0]    ta, pa, tb, pb;
  logic [31:0]    n_dt_q, n_dp_q, n_sum_q, m_dt_q, m_dp_q, m_sum_q;
  logic [31:0]    near_w, far_w, sel_w;
  logic [32:0]    rnd_w;
  logic [15:0]    arc_q;

  assign en         = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign ta = 32'(theta_a_i) << WS;
  assign pa = 32'(phi_a_i) << WS;
  assign tb = 32'(theta_b_i) << WS;
  assign pb = 32'(phi_b_i) << WS;

  // direct and mirror-point arguments, all mod a full turn
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_dt_q  <= ta - tb;
      n_dp_q  <= pa - pb;
      n_sum_q <= ta + tb;
      m_dt_q  <= ta + tb - gcd_pkg::TURN_HALF;
      m_dp_q  <= pa - pb - gcd_pkg::TURN_HALF;
      m_sum_q <= ta + gcd_pkg::TURN_HALF - tb;
    end
  end

  gcd_haversine u_near (
    .clk_i, .en_i(en), .dt_i(n_dt_q), .dp_i(n_dp_q), .sum_i(n_sum_q), .dist_o(near_w)
  );
  gcd_haversine u_far (
    .clk_i, .en_i(en), .dt_i(m_dt_q), .dp_i(m_dp_q), .sum_i(m_sum_q), .dist_o(far_w)
  );

  assign sel_w = (near_w > gcd_pkg::TURN_QUARTER) ? (gcd_pkg::TURN_HALF - far_w) : near_w;
  assign rnd_w = ({1'b0, sel_w} + RND) >> WS;

  always_ff @(posedge clk_i) begin
    if (en) begin
      arc_q <= rnd_w[15:0];
    end
  end

  assign out_valid_o  = vld_q[LAT-1];
  assign arc_length_o = arc_q;

  `GCD_ASSERT_NOW(a_stall_blocks, out_valid_o && !out_ready_i, !in_ready_o, "stall did not block input")
  `GCD_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, vld_q[0], "accepted request lost at entry")
  `GCD_ASSERT_NOW(a_dist_range, vld_q[LAT-2], sel_w <= gcd_pkg::TURN_HALF, "distance above half turn")
  `GCD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(arc_length_o), "result changed while stalled")

endmodule

### sim/tb_great_circle_distance_top.sv
`timescale 1ns / 100ps

class arc_scoreboard;
  logic [15:0] arc_queue[$];
  int unsigned mismatches;
  int unsigned checked;

  static function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  static function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  static function automatic longint half_sine(logic [31:0] full);
    logic [31:0] h;
    longint x, y, z, nx;
    h = full >> 1;
    if (h > gcd_pkg::TURN_QUARTER) h = gcd_pkg::TURN_HALF - h;
    x = 652032874;
    y = 0;
    z = longint'(h);
    for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - longint'(gcd_pkg::ATAN_TURNS[i]);
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + longint'(gcd_pkg::ATAN_TURNS[i]);
      end
      x = nx;
    end
    if (y < 0) y = 0;
    if (y > (64'd1 << 30)) y = 64'd1 << 30;
    return y;
  endfunction

  static function automatic longint sq30(longint s);
    return (s * s) >> 30;
  endfunction

  // doubled arcsine of the haversine root, in 32-bit turns
  static function automatic longint hav_arc(logic [31:0] dt, logic [31:0] dp, logic [31:0] sm);
    longint st2, sp2, ss2, v, x, y, z, nx;
    longint one;
    one = 64'd1 << 30;
    st2 = sq30(half_sine(dt));
    sp2 = sq30(half_sine(dp));
    ss2 = sq30(half_sine(sm));
    v = st2 + floor_shr(sp2 * (ss2 - st2), 30);
    if (v < 0) v = 0;
    if (v > one) v = one;
    y = isqrt(longint'(v) << 30);
    x = isqrt(longint'(one - v) << 30);
    z = 0;
    for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + longint'(gcd_pkg::ATAN_TURNS[i]);
      end else begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - longint'(gcd_pkg::ATAN_TURNS[i]);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > one) z = one;
    return z * 2;
  endfunction

  function void note_request(logic [15:0] ta_f, logic [15:0] pa_f, logic [15:0] tb_f,
                             logic [15:0] pb_f);
    logic [31:0] ta, pa, tb, pb;
    longint d;
    ta = {ta_f, 16'h0};
    pa = {pa_f, 16'h0};
    tb = {tb_f, 16'h0};
    pb = {pb_f, 16'h0};
    d = hav_arc(ta - tb, pa - pb, ta + tb);
    if (d > longint'(gcd_pkg::TURN_QUARTER))
      d = longint'(gcd_pkg::TURN_HALF) -
          hav_arc(ta + tb - gcd_pkg::TURN_HALF, pa - pb - gcd_pkg::TURN_HALF,
                  ta + gcd_pkg::TURN_HALF - tb);
    d = (d + (64'd1 << 15)) >> 16;
    arc_queue.push_back(d[15:0]);
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    if (arc_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result arc_length=%0d", got);
      return;
    end
    want = arc_queue.pop_front();
    checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("arc_length mismatch: expected %0d actual %0d", want, got);
    end
  endfunction
endclass

module tb_great_circle_distance_top;
  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic [15:0] theta_a_i, phi_a_i, theta_b_i, phi_b_i;
  logic out_valid_o, out_ready_i;
  logic [15:0] arc_length_o;
  arc_scoreboard board;
  int unsigned sent;
  bit stim_done;

  great_circle_distance_top uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_request(logic [15:0] ta, logic [15:0] pa, logic [15:0] tb,
                              logic [15:0] pb);
    in_valid_i <= 1'b1;
    theta_a_i <= ta;
    phi_a_i <= pa;
    theta_b_i <= tb;
    phi_b_i <= pb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_request(ta, pa, tb, pb);
    sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    logic [15:0] ta, tb;
    case ($urandom_range(0, 9))
      0: begin
        ta = 16'($urandom);
        tb = 16'($urandom);
      end
      1: begin
        ta = 16'($urandom_range(0, 32768));
        tb = 16'(32'd32768 - 32'(ta) + $urandom_range(0, 8) - 32'd4);
      end
      default: begin
        ta = 16'($urandom_range(0, 32768));
        tb = 16'($urandom_range(0, 32768));
      end
    endcase
    send_request(ta, 16'($urandom), tb, 16'($urandom));
  endtask

  // output stall pattern: ready drawn independently at random, high more often than low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 15) < 11);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(arc_length_o);
  end

  initial begin
    int burst;
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    theta_a_i = '0;
    phi_a_i = '0;
    theta_b_i = '0;
    phi_b_i = '0;
    sent = 0;
    stim_done = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: identical, antipodal, poles, wrap, out-of-range bit patterns
    send_request(16'd0, 16'd0, 16'd0, 16'd0);
    send_request(16'd32768, 16'd0, 16'd0, 16'd0);
    send_request(16'd16384, 16'd0, 16'd16384, 16'd32768);
    send_request(16'd16384, 16'd0, 16'd16384, 16'd16384);
    send_request(16'd16384, 16'd65535, 16'd16384, 16'd0);
    send_request(16'd32768, 16'd65535, 16'd32768, 16'd0);
    send_request(16'd100, 16'd1, 16'd32668, 16'd32769);
    send_request(16'd16384, 16'd0, 16'd16383, 16'd32768);
    send_request(16'd16384, 16'd12000, 16'd16384, 16'd12001);
    send_request(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(16'hffff, 16'h0000, 16'h0000, 16'hffff);
    send_request(16'h8001, 16'h5555, 16'hc000, 16'haaaa);
    send_request(16'd1, 16'd0, 16'd0, 16'd0);
    send_request(16'd8192, 16'd49152, 16'd24576, 16'd16384);
    send_request(16'd20000, 16'd40000, 16'd12768, 16'd7232);
    idle_gap(3);
    while (sent < 535) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (burst) send_random();
      idle_gap($urandom_range(0, 6));
    end
    in_valid_i <= 1'b0;
    while (board.arc_queue.size() != 0) @(posedge clk_i);
    repeat (gcd_pkg::LATENCY + 10) @(posedge clk_i);
    $display("sent %0d point pairs, checked %0d distances", sent, board.checked);
    $display("directed poles, antipodes and wrap cases plus random bursts with output stalls");
    if (board.mismatches == 0 && board.arc_queue.size() == 0) begin
      $display("great_circle_distance_top: match");
    end else begin
      $display("great_circle_distance_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("great_circle_distance_top: mismatch");
    $finish;
  end
endmodule

### great_circle_distance_top.f
+incdir+hw/rtl
hw/rtl/gcd_pkg.sv
hw/rtl/gcd_sin_cordic.sv
hw/rtl/gcd_isqrt.sv
hw/rtl/gcd_asin_cordic.sv
hw/rtl/gcd_haversine.sv
hw/rtl/great_circle_distance_top.sv
sim/tb_great_circle_distance_top.sv
